/* design/hhm_pkg.sv */
`timescale 1ns / 1ps

package hhm_pkg;

   // Default and largest number of watched subsystems.
   localparam int SUBSYSTEMS_DEF = 4;
   localparam int MAX_SUBSYSTEMS = 4;

   localparam int TIME_W   = 16;
   localparam int MISS_W   = 8;
   localparam int COUNT_W  = 3;
   localparam int VECTOR_W = 2 * MAX_SUBSYSTEMS;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIME_W-1:0] TIME_MAX     = '1;
   localparam logic [MISS_W-1:0] MISS_MAX     = '1;
   localparam logic [TIME_W-1:0] DEADLINE_RST = 16'd250;
   localparam logic [TIME_W-1:0] PERIOD_RST   = 16'd500;

   // A system shutdown is declared when at least this many subsystems fail in one check.
   localparam logic [COUNT_W-1:0] SHUTDOWN_LIMIT = 3'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DEADLINE_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_PERIOD = 3'd4;

   // Input item kinds.
   localparam logic FUNC_TICK      = 1'b0;
   localparam logic FUNC_HEARTBEAT = 1'b1;

   typedef enum logic [1:0] {
      ST_HEALTHY  = 2'd0,
      ST_WARNING  = 2'd1,
      ST_FAILED   = 2'd2,
      ST_SHUTDOWN = 2'd3
   } status_type;

   // Outcome of checking one subsystem.
   typedef struct packed {
      status_type        status;
      logic [MISS_W-1:0] miss;
      logic              failed;
   } chk_result_type;

endpackage

/* design/hhm_csr.sv */
`timescale 1ns / 1ps

module hhm_csr #(
   parameter int SUBSYSTEMS = hhm_pkg::SUBSYSTEMS_DEF,
   parameter int IDX_W      = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hhm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hhm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [IDX_W-1:0]                 sel_idx,
   output logic [hhm_pkg::TIME_W-1:0]       deadline_sel,
   output logic [hhm_pkg::TIME_W-1:0]       check_period
);

   logic [hhm_pkg::TIME_W-1:0] deadline_ff [SUBSYSTEMS];
   logic [hhm_pkg::TIME_W-1:0] deadline_in [SUBSYSTEMS];
   logic [hhm_pkg::TIME_W-1:0] period_ff;
   logic [hhm_pkg::TIME_W-1:0] period_in;

   always_comb begin
      for (int i = 0; i < SUBSYSTEMS; i++) begin
         deadline_in[i] = deadline_ff[i];
         if (csr_we && csr_index == hhm_pkg::CSR_DEADLINE_0 + hhm_pkg::CSR_IDX_W'(i)) begin
            deadline_in[i] = csr_wdata;
         end
      end
      period_in = period_ff;
      if (csr_we && csr_index == hhm_pkg::CSR_CHECK_PERIOD) begin
         period_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SUBSYSTEMS; i++) begin
            deadline_ff[i] <= hhm_pkg::DEADLINE_RST;
         end
         period_ff <= hhm_pkg::PERIOD_RST;
      end else begin
         deadline_ff <= deadline_in;
         period_ff   <= period_in;
      end
   end

   assign deadline_sel = deadline_ff[sel_idx];
   assign check_period = period_ff;

endmodule

/* design/hhm_check_unit.sv */
`timescale 1ns / 1ps

module hhm_check_unit (
   input  hhm_pkg::status_type              status,
   input  logic [hhm_pkg::MISS_W-1:0]       miss,
   input  logic [hhm_pkg::TIME_W-1:0]       since,
   input  logic [hhm_pkg::TIME_W-1:0]       deadline,
   output hhm_pkg::chk_result_type          result
);

   logic [hhm_pkg::MISS_W-1:0] miss_inc;

   assign miss_inc = (miss == hhm_pkg::MISS_MAX) ? miss : hhm_pkg::MISS_W'(miss + 1'b1);

   always_comb begin
      result.status = status;
      result.miss   = miss;
      result.failed = 1'b0;
      if (status == hhm_pkg::ST_SHUTDOWN) begin
         result.failed = 1'b1;
      end else if (since > deadline) begin
         result.miss = miss_inc;
         // Only the first miss since the count was last cleared is a warning; every later one is a failure.
         if (miss_inc == hhm_pkg::MISS_W'(1)) begin
            result.status = hhm_pkg::ST_WARNING;
         end else begin
            result.status = hhm_pkg::ST_FAILED;
            result.failed = 1'b1;
         end
      end else if (miss != '0 && status != hhm_pkg::ST_FAILED) begin
         result.miss   = '0;
         result.status = hhm_pkg::ST_HEALTHY;
      end
   end

endmodule

/* design/heartbeat_health_monitor.sv */
`timescale 1ns / 1ps
// A tick that starts a health check moves through S_CHECK, where the shared check
// unit walks the subsystems one per cycle, and S_FINISH, which loads the registered
// result; heartbeats and other ticks give no result. Throughput: one item per cycle
// while idle; req_ready stays low from the start of a check until S_FINISH loads its
// result, which waits for as long as the previous result still waits on rsp_ready.
// Reset is synchronous, active high; it restores all but the result data registers.
module heartbeat_health_monitor #(
   parameter int SUBSYSTEMS = hhm_pkg::SUBSYSTEMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [1:0]                          req_subsystem,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hhm_pkg::VECTOR_W-1:0]        rsp_status_vector,
   output logic [hhm_pkg::COUNT_W-1:0]         rsp_failed_total,
   output logic                                rsp_degraded,
   output logic                                rsp_system_shutdown,
   input  logic                                csr_we,
   input  logic [hhm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hhm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = (SUBSYSTEMS > 1) ? $clog2(SUBSYSTEMS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SUBSYSTEMS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [hhm_pkg::COUNT_W-1:0] fail_cnt_ff, fail_cnt_in;
   logic [hhm_pkg::TIME_W-1:0] period_ff, period_in;
   logic halted_ff, halted_in;
   logic [hhm_pkg::TIME_W-1:0] since_ff [SUBSYSTEMS];
   logic [hhm_pkg::TIME_W-1:0] since_in [SUBSYSTEMS];
   logic [hhm_pkg::MISS_W-1:0] miss_ff [SUBSYSTEMS];
   logic [hhm_pkg::MISS_W-1:0] miss_in [SUBSYSTEMS];
   hhm_pkg::status_type status_ff [SUBSYSTEMS];
   hhm_pkg::status_type status_in [SUBSYSTEMS];

   logic rsp_valid_ff, rsp_valid_in;
   logic [hhm_pkg::VECTOR_W-1:0] rsp_vector_ff, rsp_vector_in;
   logic [hhm_pkg::COUNT_W-1:0] rsp_total_ff, rsp_total_in;
   logic rsp_degraded_ff, rsp_degraded_in;
   logic rsp_shutdown_ff, rsp_shutdown_in;

   logic [hhm_pkg::TIME_W-1:0] deadline_sel;
   logic [hhm_pkg::TIME_W-1:0] check_period;
   logic [hhm_pkg::TIME_W-1:0] period_inc;
   hhm_pkg::chk_result_type chk_res;
   logic req_xfer;
   logic halt_now;

   hhm_csr #(
      .SUBSYSTEMS (SUBSYSTEMS),
      .IDX_W      (IDX_W)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sel_idx      (idx_ff),
      .deadline_sel (deadline_sel),
      .check_period (check_period)
   );

   hhm_check_unit u_check (
      .status   (status_ff[idx_ff]),
      .miss     (miss_ff[idx_ff]),
      .since    (since_ff[idx_ff]),
      .deadline (deadline_sel),
      .result   (chk_res)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign period_inc = (period_ff == hhm_pkg::TIME_MAX) ? period_ff
                                                         : hhm_pkg::TIME_W'(period_ff + 1'b1);
   assign halt_now   = (fail_cnt_ff >= hhm_pkg::SHUTDOWN_LIMIT);

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      fail_cnt_in     = fail_cnt_ff;
      period_in       = period_ff;
      halted_in       = halted_ff;
      since_in        = since_ff;
      miss_in         = miss_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_vector_in   = rsp_vector_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_degraded_in = rsp_degraded_ff;
      rsp_shutdown_in = rsp_shutdown_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_func == hhm_pkg::FUNC_HEARTBEAT) begin
                  for (int i = 0; i < SUBSYSTEMS; i++) begin
                     if (req_subsystem == 2'(i)) begin
                        since_in[i] = '0;
                     end
                  end
               end else begin
                  for (int i = 0; i < SUBSYSTEMS; i++) begin
                     if (since_ff[i] != hhm_pkg::TIME_MAX) begin
                        since_in[i] = hhm_pkg::TIME_W'(since_ff[i] + 1'b1);
                     end
                  end
                  // Once halted, the period counter freezes and no check runs.
                  if (!halted_ff) begin
                     if (period_inc >= check_period) begin
                        period_in   = '0;
                        idx_in      = '0;
                        fail_cnt_in = '0;
                        state_in    = S_CHECK;
                     end else begin
                        period_in = period_inc;
                     end
                  end
               end
            end
         end
         S_CHECK: begin
            status_in[idx_ff] = chk_res.status;
            miss_in[idx_ff]   = chk_res.miss;
            fail_cnt_in       = hhm_pkg::COUNT_W'(fail_cnt_ff + chk_res.failed);
            if (idx_ff == LAST_IDX) begin
               state_in = S_FINISH;
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         S_FINISH: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_vector_in = '0;
               for (int i = 0; i < SUBSYSTEMS; i++) begin
                  if (halt_now) begin
                     status_in[i] = hhm_pkg::ST_SHUTDOWN;
                  end
                  rsp_vector_in[2*i +: 2] = halt_now ? hhm_pkg::ST_SHUTDOWN : status_ff[i];
               end
               if (halt_now) begin
                  halted_in = 1'b1;
               end
               rsp_valid_in    = 1'b1;
               rsp_total_in    = fail_cnt_ff;
               rsp_degraded_in = (fail_cnt_ff != '0);
               rsp_shutdown_in = halt_now;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         fail_cnt_ff  <= '0;
         period_ff    <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SUBSYSTEMS; i++) begin
            since_ff[i]  <= '0;
            miss_ff[i]   <= '0;
            status_ff[i] <= hhm_pkg::ST_HEALTHY;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fail_cnt_ff  <= fail_cnt_in;
         period_ff    <= period_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         since_ff     <= since_in;
         miss_ff      <= miss_in;
         status_ff    <= status_in;
      end
      rsp_vector_ff   <= rsp_vector_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_degraded_ff <= rsp_degraded_in;
      rsp_shutdown_ff <= rsp_shutdown_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status_vector   = rsp_vector_ff;
   assign rsp_failed_total    = rsp_total_ff;
   assign rsp_degraded        = rsp_degraded_ff;
   assign rsp_system_shutdown = rsp_shutdown_ff;

   // A halt is always announced by a result that reports the shutdown.
   assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |-> rsp_valid_ff && rsp_shutdown_ff)
      else $error("halt without a shutdown result");

   // The degraded flag must agree with the failure count of the same result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_degraded_ff == (rsp_total_ff != '0))
      else $error("degraded flag disagrees with failed total");

   // After a halt the period counter never moves again.
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> $stable(period_ff))
      else $error("period counter moved while halted");

   // The failure count can never exceed the number of subsystems.
   assert property (@(posedge clock) disable iff (reset)
      fail_cnt_ff <= hhm_pkg::COUNT_W'(SUBSYSTEMS))
      else $error("failure count out of range");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int SUBS         = hhm_pkg::SUBSYSTEMS_DEF;
   localparam int DRAIN_CYCLES = SUBS + 4;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 110;

   // Index past the register list; writes to it must have no effect.
   localparam logic [hhm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [3:0][hhm_pkg::TIME_W-1:0] elapsed;
      logic [3:0][hhm_pkg::MISS_W-1:0] misses;
      logic [3:0][1:0]                 status;
      logic [hhm_pkg::TIME_W-1:0]      ticks;
      logic                            halted;
   } watch_type;

   typedef struct packed {
      logic [hhm_pkg::VECTOR_W-1:0] status_vector;
      logic [hhm_pkg::COUNT_W-1:0]  failed_total;
      logic                         degraded;
      logic                         system_shutdown;
   } report_type;

   typedef struct packed {
      watch_type  st;
      logic       fired;
      report_type rep;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   logic [1:0] req_subsystem = 2'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [hhm_pkg::VECTOR_W-1:0] rsp_status_vector;
   logic [hhm_pkg::COUNT_W-1:0] rsp_failed_total;
   logic rsp_degraded;
   logic rsp_system_shutdown;
   logic csr_we = 1'b0;
   logic [hhm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [hhm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   watch_type watch = '0;
   logic [3:0][hhm_pkg::TIME_W-1:0] deadline_cfg = {4{hhm_pkg::DEADLINE_RST}};
   logic [hhm_pkg::TIME_W-1:0] period_cfg = hhm_pkg::PERIOD_RST;
   report_type expected_reports[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;
   int rsp_wait = 0;
   logic long_hold_request = 1'b0;

   heartbeat_health_monitor #(.SUBSYSTEMS(SUBS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_subsystem(req_subsystem),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status_vector(rsp_status_vector),
      .rsp_failed_total(rsp_failed_total),
      .rsp_degraded(rsp_degraded),
      .rsp_system_shutdown(rsp_system_shutdown),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Next watchdog state for one item, plus the health report when a check runs.
   function automatic step_type advance_watch(watch_type s, logic func, logic [1:0] sub);
      step_type r;
      logic [hhm_pkg::COUNT_W-1:0] nfail;
      r = '0;
      r.st = s;
      nfail = '0;
      if (func == hhm_pkg::FUNC_HEARTBEAT) begin
         if (int'(sub) < SUBS) r.st.elapsed[sub] = '0;
         return r;
      end
      for (int i = 0; i < SUBS; i++) begin
         if (r.st.elapsed[i] != hhm_pkg::TIME_MAX) r.st.elapsed[i] = r.st.elapsed[i] + 1'b1;
      end
      if (r.st.halted) return r;
      if (r.st.ticks != hhm_pkg::TIME_MAX) r.st.ticks = r.st.ticks + 1'b1;
      // A period of zero behaves like one since the count is at least one here.
      if (r.st.ticks < period_cfg) return r;
      r.st.ticks = '0;
      r.fired = 1'b1;
      for (int i = 0; i < SUBS; i++) begin
         if (r.st.status[i] == hhm_pkg::ST_SHUTDOWN) begin
            nfail = nfail + 1'b1;
         end else if (r.st.elapsed[i] > deadline_cfg[i]) begin
            if (r.st.misses[i] != hhm_pkg::MISS_MAX) r.st.misses[i] = r.st.misses[i] + 1'b1;
            if (r.st.misses[i] == 8'd1) begin
               r.st.status[i] = hhm_pkg::ST_WARNING;
            end else begin
               r.st.status[i] = hhm_pkg::ST_FAILED;
               nfail = nfail + 1'b1;
            end
         end else if (r.st.misses[i] != '0 && r.st.status[i] != hhm_pkg::ST_FAILED) begin
            r.st.misses[i] = '0;
            r.st.status[i] = hhm_pkg::ST_HEALTHY;
         end
      end
      if (nfail >= hhm_pkg::SHUTDOWN_LIMIT) begin
         for (int i = 0; i < SUBS; i++) r.st.status[i] = hhm_pkg::ST_SHUTDOWN;
         r.st.halted = 1'b1;
      end
      for (int i = 0; i < SUBS; i++) r.rep.status_vector[2*i +: 2] = r.st.status[i];
      r.rep.failed_total = nfail;
      r.rep.degraded = (nfail != '0);
      r.rep.system_shutdown = (nfail >= hhm_pkg::SHUTDOWN_LIMIT);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input report_type want,
                                input report_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected vector %h failed %0d degraded %b shutdown %b,",
                  $realtime, what, want.status_vector, want.failed_total, want.degraded,
                  want.system_shutdown);
         $display("   got vector %h failed %0d degraded %b shutdown %b",
                  got.status_vector, got.failed_total, got.degraded, got.system_shutdown);
      end
   endtask

   always @(posedge clock) begin : check_reports
      report_type got;
      report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status_vector, rsp_failed_total, rsp_degraded, rsp_system_shutdown};
         if (expected_reports.size() == 0) begin
            note_mismatch("unexpected report", '0, got);
         end else begin
            want = expected_reports.pop_front();
            if (got.status_vector !== want.status_vector
                || got.failed_total !== want.failed_total
                || got.degraded !== want.degraded
                || got.system_shutdown !== want.system_shutdown) begin
               note_mismatch("report mismatch", want, got);
            end
         end
      end
   end

   // Result side: random stalls, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (long_hold_request) begin
         long_hold_request = 1'b0;
         rsp_wait = 400;
      end
      if (rsp_wait > 0) begin
         rsp_wait = rsp_wait - 1;
         rsp_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_wait = $urandom_range(1, 13) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic func, input logic [1:0] sub);
      int gap;
      step_type nxt;
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_subsystem <= sub;
      do begin
         @(posedge clock);
      end while (!req_ready);
      nxt = advance_watch(watch, func, sub);
      watch = nxt.st;
      if (nxt.fired) expected_reports = {expected_reports, nxt.rep};
   endtask

   // Waits for all reports, then lets a tick still in flight finish.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      for (int w = 0; w < 20000 && expected_reports.size() != 0; w++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         if (mismatch_count < 10) $display("%0d reports never arrived", expected_reports.size());
         mismatch_count += expected_reports.size();
         expected_reports.delete();
      end
   endtask

   task automatic write_csr(input logic [hhm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hhm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx < hhm_pkg::CSR_CHECK_PERIOD) deadline_cfg[idx[1:0]] = data;
      else if (idx == hhm_pkg::CSR_CHECK_PERIOD) period_cfg = data;
   endtask

   // Unless a shutdown is wanted, a tick that would fail two subsystems at once
   // is replaced by a heartbeat to one of the late ones. At most one deadline is
   // zero in such phases, so this always makes progress.
   task automatic random_item(input logic allow_halt);
      step_type probe;
      logic [1:0] sub;
      sub = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 55) begin
         probe = advance_watch(watch, hhm_pkg::FUNC_TICK, sub);
         if (!allow_halt && probe.fired && probe.rep.system_shutdown) begin
            for (int i = SUBS - 1; i >= 0; i--) begin
               if (deadline_cfg[i] != '0 && watch.elapsed[i] >= deadline_cfg[i]) sub = 2'(i);
            end
            send_item(hhm_pkg::FUNC_HEARTBEAT, sub);
         end else begin
            send_item(hhm_pkg::FUNC_TICK, sub);
         end
      end else begin
         send_item(hhm_pkg::FUNC_HEARTBEAT, sub);
      end
   endtask

   task automatic new_settings();
      logic zero_used;
      logic [hhm_pkg::TIME_W-1:0] d;
      zero_used = 1'b0;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 7))
            0: d = '0;
            1: d = 16'd1;
            2: d = hhm_pkg::TIME_MAX;
            3: d = 16'($urandom_range(0, 65535));
            default: d = 16'($urandom_range(2, 10));
         endcase
         if (d == '0) begin
            if (zero_used) d = 16'd1;
            zero_used = 1'b1;
         end
         write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'(i), d);
      end
      case ($urandom_range(0, 9))
         0: d = '0;
         9: d = 16'($urandom_range(20, 60));
         default: d = 16'($urandom_range(1, 8));
      endcase
      write_csr(hhm_pkg::CSR_CHECK_PERIOD, d);
      case ($urandom_range(0, 3))
         0: idle_pct = 0;
         1: idle_pct = 5;
         2: idle_pct = 12;
         default: idle_pct = 25;
      endcase
   endtask

   task automatic test_directed_cases();
      idle_pct = 0;
      // With the reset period no check is due yet.
      send_item(hhm_pkg::FUNC_TICK, 2'd0);
      send_item(hhm_pkg::FUNC_HEARTBEAT, 2'd3);
      settle();
      write_csr(hhm_pkg::CSR_CHECK_PERIOD, 16'd0);
      write_csr(hhm_pkg::CSR_DEADLINE_0, 16'd0);
      write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'd1, 16'd2);
      write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'd2, hhm_pkg::TIME_MAX);
      write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'd3, hhm_pkg::TIME_MAX);
      write_csr(CSR_UNUSED, 16'd0);
      for (int i = 0; i < 4; i++) send_item(hhm_pkg::FUNC_HEARTBEAT, 2'(i));
      // The subsystem field of a tick is ignored.
      send_item(hhm_pkg::FUNC_TICK, 2'd3);
      send_item(hhm_pkg::FUNC_TICK, 2'd0);
      send_item(hhm_pkg::FUNC_TICK, 2'd1);
      send_item(hhm_pkg::FUNC_HEARTBEAT, 2'd1);
      send_item(hhm_pkg::FUNC_TICK, 2'd2);
      send_item(hhm_pkg::FUNC_HEARTBEAT, 2'd0);
      send_item(hhm_pkg::FUNC_TICK, 2'd0);
      settle();
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < PHASES; p++) begin
         new_settings();
         if (p == 1) long_hold_request = 1'b1;
         repeat (PHASE_ITEMS) random_item(1'b0);
         settle();
      end
   endtask

   task automatic test_counter_saturation();
      idle_pct = 5;
      write_csr(hhm_pkg::CSR_CHECK_PERIOD, 16'd0);
      write_csr(hhm_pkg::CSR_DEADLINE_0, 16'd0);
      for (int i = 1; i < 4; i++) write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'(i), hhm_pkg::TIME_MAX);
      // Enough misses to pin the miss count at its maximum.
      repeat (300) send_item(hhm_pkg::FUNC_TICK, 2'($urandom_range(0, 3)));
      settle();
      idle_pct = 0;
      write_csr(hhm_pkg::CSR_CHECK_PERIOD, 16'd1);
      repeat (3) send_item(hhm_pkg::FUNC_TICK, 2'd2);
      settle();
   endtask

   task automatic test_system_shutdown();
      idle_pct = 0;
      write_csr(hhm_pkg::CSR_CHECK_PERIOD, 16'd1);
      write_csr(hhm_pkg::CSR_DEADLINE_0, 16'd0);
      write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'd1, 16'd0);
      write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'd2, 16'd3);
      write_csr(hhm_pkg::CSR_DEADLINE_0 + 3'd3, hhm_pkg::TIME_MAX);
      // Two subsystems fail quickly; the rest of the items run while halted.
      repeat (80) random_item(1'b1);
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic();
      test_counter_saturation();
      test_system_shutdown();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
